// File: src/ssq_pkg.sv
// Shared types and codes for the sorted sleep queue wakeup core.
`timescale 1ns / 1ps

package ssq_pkg;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_SLEEP = 1'b1;

    localparam logic [1:0] KIND_SLEEP_OK  = 2'd0;
    localparam logic [1:0] KIND_FULL      = 2'd1;
    localparam logic [1:0] KIND_IDLE_TICK = 2'd2;
    localparam logic [1:0] KIND_WOKEN     = 2'd3;

    typedef struct packed {
        logic        command;
        logic [7:0]  thread_id;
        logic [31:0] duration;
        logic [5:0]  thread_priority;
        logic [5:0]  running_priority;
    } t_in_item;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] woken_id;
        logic       yield_request;
        logic       last;
    } t_out_item;

endpackage

// File: src/ssq_engine.sv
// Sleep queue engine: tick count, circular entry memory and the insert/wake sequencer.
`timescale 1ns / 1ps

module ssq_engine #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 6
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    input  ssq_pkg::t_in_item i_req,
    output logic              o_req_ready,
    output logic              o_res_valid,
    output ssq_pkg::t_out_item o_res,
    input  logic              i_res_ready
);

    localparam int IDK   = (ID_BITS < 8) ? ID_BITS : 8;
    localparam int PRK   = (PRIORITY_BITS < 6) ? PRIORITY_BITS : 6;
    localparam int EW    = 64 + IDK + PRK;
    localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W = OCC_W + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_PUT  = 3'd2;
    localparam logic [2:0] S_TICK = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_W'(QUEUE_DEPTH - 1) : p - 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] b,
                                                 input logic [OCC_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(b) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH)) begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    logic [EW-1:0] mem [QUEUE_DEPTH];
    logic [EW-1:0] r_rd;

    logic [2:0]         r_state, n_state;
    logic [63:0]        r_count, n_count;
    logic [OCC_W-1:0]   r_occ, n_occ;
    logic [PTR_W-1:0]   r_head, n_head;
    logic [PTR_W-1:0]   r_idx, n_idx;
    logic [OCC_W-1:0]   r_left, n_left;
    logic [63:0]        r_wake, n_wake;
    logic               r_pend, n_pend;
    ssq_pkg::t_in_item  r_req, n_req;
    ssq_pkg::t_out_item r_res, n_res;

    logic             rd_en, wr_en;
    logic [PTR_W-1:0] rd_addr, wr_addr;
    logic [EW-1:0]    wr_data;
    logic [EW-1:0]    new_entry;
    logic [63:0]      rd_wake;
    logic [IDK-1:0]   rd_id;
    logic [PRK-1:0]   rd_prio;
    logic             hit;
    logic             go;

    assign new_entry = {r_wake, r_req.thread_id[IDK-1:0], r_req.thread_priority[PRK-1:0]};
    assign rd_wake   = r_rd[EW-1 -: 64];
    assign rd_id     = r_rd[PRK +: IDK];
    assign rd_prio   = r_rd[PRK-1:0];
    assign hit       = (rd_wake <= r_count);
    assign go        = !r_pend || i_res_ready;
    assign o_req_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_occ   = r_occ;
        n_head  = r_head;
        n_idx   = r_idx;
        n_left  = r_left;
        n_wake  = r_wake;
        n_pend  = r_pend;
        n_req   = r_req;
        n_res   = r_res;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        o_res_valid = 1'b0;
        o_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req = i_req;
                    if (i_req.command == ssq_pkg::CMD_SLEEP) begin
                        if (r_occ == OCC_W'(QUEUE_DEPTH)) begin
                            n_res   = '{ssq_pkg::KIND_FULL, 8'd0, 1'b0, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            n_wake = r_count + 64'(i_req.duration);
                            if (r_occ == '0) begin
                                n_idx   = r_head;
                                n_state = S_PUT;
                            end else begin
                                n_idx   = ptr_add(r_head, r_occ - 1'b1);
                                rd_en   = 1'b1;
                                rd_addr = ptr_add(r_head, r_occ - 1'b1);
                                n_left  = r_occ;
                                n_state = S_INS;
                            end
                        end
                    end else begin
                        n_count = r_count + 64'd1;
                        if (r_occ == '0) begin
                            n_res   = '{ssq_pkg::KIND_IDLE_TICK, 8'd0, 1'b0, 1'b1};
                            n_state = S_EMIT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_pend  = 1'b0;
                            n_state = S_TICK;
                        end
                    end
                end
            end
            S_INS: begin
                if (rd_wake > r_wake) begin
                    wr_en   = 1'b1;
                    wr_addr = ptr_next(r_idx);
                    wr_data = r_rd;
                    if (r_left == OCC_W'(1)) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx   = ptr_prev(r_idx);
                        rd_en   = 1'b1;
                        rd_addr = ptr_prev(r_idx);
                        n_left  = r_left - 1'b1;
                    end
                end else begin
                    n_idx   = ptr_next(r_idx);
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                wr_en   = 1'b1;
                wr_addr = r_idx;
                wr_data = new_entry;
                n_occ   = r_occ + 1'b1;
                n_res   = '{ssq_pkg::KIND_SLEEP_OK, 8'd0, 1'b0, 1'b1};
                n_state = S_EMIT;
            end
            S_TICK: begin
                if (hit) begin
                    o_res_valid = r_pend;
                    if (go) begin
                        n_head = ptr_next(r_head);
                        n_occ  = r_occ - 1'b1;
                        n_pend = 1'b1;
                        n_res  = '{ssq_pkg::KIND_WOKEN, 8'(rd_id),
                                   rd_prio > r_req.running_priority[PRK-1:0],
                                   r_occ == OCC_W'(1)};
                        if (r_occ == OCC_W'(1)) begin
                            n_state = S_EMIT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = ptr_next(r_head);
                        end
                    end
                end else begin
                    if (r_pend) begin
                        n_res.last = 1'b1;
                    end else begin
                        n_res = '{ssq_pkg::KIND_IDLE_TICK, 8'd0, 1'b0, 1'b1};
                    end
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_occ   <= '0;
            r_head  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_occ   <= n_occ;
            r_head  <= n_head;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx  <= n_idx;
        r_left <= n_left;
        r_wake <= n_wake;
        r_req  <= n_req;
        r_res  <= n_res;
    end

endmodule

// File: src/sorted_sleep_queue_wakeup_core.sv
// Top level of the sorted sleep queue wakeup core: channels and output register.
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+-------------------------------
//  in      | i_in_valid  | o_in_stall   | i_in_data  (ssq_pkg::t_in_item)
//  out     | o_out_valid | i_out_stall  | o_out_data (ssq_pkg::t_out_item)
//
// One item at a time. A sleep walks the queue from its tail, one entry per cycle
// through the entry memory port, moving each later entry up one place; the walk ends
// where the new entry lands, at the head at most. A sleep on a full queue is refused.
// A tick wakes every due thread from the head of the queue; one memory read per entry.
// Reset clears the tick count and empties the queue; the memory needs no clearing.
// A stalled result holds in the output register; the engine waits for it to drain.
`timescale 1ns / 1ps

module sorted_sleep_queue_wakeup_core #(
    parameter int QUEUE_DEPTH   = 16,
    parameter int ID_BITS       = 8,
    parameter int PRIORITY_BITS = 6
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  ssq_pkg::t_in_item  i_in_data,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output ssq_pkg::t_out_item o_out_data,
    input  logic               i_out_stall
);

    logic               eng_ready;
    logic               res_valid;
    ssq_pkg::t_out_item res;
    logic               out_free;
    logic               r_out_valid;
    ssq_pkg::t_out_item r_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = !eng_ready;

    ssq_engine #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .ID_BITS      (ID_BITS),
        .PRIORITY_BITS(PRIORITY_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_in_valid),
        .i_req      (i_in_data),
        .o_req_ready(eng_ready),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ready(out_free)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// File: tb/tb.sv
// Self-checking testbench for the sorted sleep queue wakeup core.
`timescale 1ns / 1ps

module tb;

    localparam int QDEPTH       = 16;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    ssq_pkg::t_in_item  in_data   = '0;
    logic               in_stall;
    logic               out_valid;
    ssq_pkg::t_out_item out_data;
    logic               out_stall = 1'b0;

    ssq_pkg::t_in_item  pending[$];
    ssq_pkg::t_out_item results_due[$];

    logic [63:0] now_tick;
    logic [63:0] q_wake[QDEPTH];
    logic [7:0]  q_id[QDEPTH];
    logic [5:0]  q_prio[QDEPTH];
    int          q_count;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int quiet          = 0;
    int mismatches     = 0;

    sorted_sleep_queue_wakeup_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Wakeup queue predictor: sorted insert on sleep, head pops on tick.
    function automatic void predict_wakeups(input ssq_pkg::t_in_item it);
        logic [63:0]        wake;
        int                 pos;
        int                 n;
        ssq_pkg::t_out_item r;
        r = '0;
        if (it.command == ssq_pkg::CMD_SLEEP) begin
            r.last = 1'b1;
            if (q_count >= QDEPTH) begin
                r.kind = ssq_pkg::KIND_FULL;
            end else begin
                r.kind = ssq_pkg::KIND_SLEEP_OK;
                wake = now_tick + 64'(it.duration);
                pos = 0;
                while (pos < q_count && q_wake[pos] <= wake) pos++;
                for (int i = q_count; i > pos; i--) begin
                    q_wake[i] = q_wake[i - 1];
                    q_id[i]   = q_id[i - 1];
                    q_prio[i] = q_prio[i - 1];
                end
                q_wake[pos] = wake;
                q_id[pos]   = it.thread_id;
                q_prio[pos] = it.thread_priority;
                q_count++;
            end
            results_due.push_back(r);
        end else begin
            now_tick = now_tick + 64'd1;
            n = 0;
            while (n < q_count && q_wake[n] <= now_tick) n++;
            if (n == 0) begin
                r.kind = ssq_pkg::KIND_IDLE_TICK;
                r.last = 1'b1;
                results_due.push_back(r);
            end else begin
                for (int i = 0; i < n; i++) begin
                    r.kind          = ssq_pkg::KIND_WOKEN;
                    r.woken_id      = q_id[i];
                    r.yield_request = (q_prio[i] > it.running_priority);
                    r.last          = (i == n - 1);
                    results_due.push_back(r);
                end
                for (int i = n; i < q_count; i++) begin
                    q_wake[i - n] = q_wake[i];
                    q_id[i - n]   = q_id[i];
                    q_prio[i - n] = q_prio[i];
                end
                q_count = q_count - n;
            end
        end
    endfunction

    function automatic void flag_mismatch(input string what,
                                          input ssq_pkg::t_out_item want,
                                          input ssq_pkg::t_out_item got);
        mismatches++;
        if (mismatches <= 10)
            $display("MISMATCH %s: expected kind=%0d id=%0d yield=%0b last=%0b",
                     what, want.kind, want.woken_id, want.yield_request, want.last,
                     " | got kind=%0d id=%0d yield=%0b last=%0b",
                     got.kind, got.woken_id, got.yield_request, got.last);
    endfunction

    always @(posedge clk) begin : driver
        logic take;
        if (!rst_n) begin
            in_valid <= 1'b0;
            now_tick = '0;
            q_count  = 0;
        end else begin
            take = in_valid && !in_stall;
            if (take) begin
                predict_wakeups(in_data);
                pending.delete(0);
            end
            if (!in_valid || take) begin
                if (pending.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    in_valid <= 1'b1;
                    in_data  <= pending[0];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : hold_count
        if (hold_left > 0) hold_left <= hold_left - 1;
    end

    always @(posedge clk) begin : receiver
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk) begin : monitor
        ssq_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (results_due.size() == 0) begin
                flag_mismatch("unexpected transfer", '0, out_data);
            end else begin
                want = results_due.pop_front();
                if (want.kind !== out_data.kind || want.woken_id !== out_data.woken_id
                    || want.yield_request !== out_data.yield_request
                    || want.last !== out_data.last)
                    flag_mismatch("wrong transfer", want, out_data);
            end
        end
    end

    always @(posedge clk) begin : watchdog
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic void push_item(input logic cmd, input logic [7:0] id,
                                      input logic [31:0] dur, input logic [5:0] tp,
                                      input logic [5:0] rp);
        ssq_pkg::t_in_item it;
        it.command          = cmd;
        it.thread_id        = id;
        it.duration         = dur;
        it.thread_priority  = tp;
        it.running_priority = rp;
        pending.push_back(it);
    endfunction

    // Sleep bursts then tick runs, with the odd fully random item mixed in.
    function automatic void queue_random(input int count);
        int made;
        int k;
        made = 0;
        while (made < count) begin
            if ($urandom_range(9) == 0) begin
                push_item(1'($urandom), 8'($urandom), $urandom, 6'($urandom), 6'($urandom));
                made++;
            end else begin
                k = $urandom_range(1, 5);
                repeat (k) push_item(ssq_pkg::CMD_SLEEP, 8'($urandom),
                                     ($urandom_range(7) == 0) ? $urandom_range(0, 40)
                                                              : $urandom_range(0, 6),
                                     6'($urandom), 6'($urandom));
                made += k;
                k = $urandom_range(1, 5);
                repeat (k) push_item(ssq_pkg::CMD_TICK, 8'($urandom), $urandom,
                                     6'($urandom), 6'($urandom));
                made += k;
            end
        end
    endfunction

    task automatic wait_drained();
        while (pending.size() != 0 || results_due.size() != 0) @(negedge clk);
    endtask

    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: idle tick, yield edges, equal deadlines, zero and max duration
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h00);
        push_item(ssq_pkg::CMD_SLEEP, 8'h00, 32'd0,        6'h3f, 6'h3f);
        push_item(ssq_pkg::CMD_TICK,  8'hff, 32'hffffffff, 6'h3f, 6'h00);
        push_item(ssq_pkg::CMD_SLEEP, 8'hff, 32'd0,        6'h00, 6'h00);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h3f);
        push_item(ssq_pkg::CMD_SLEEP, 8'h11, 32'd0,        6'h05, 6'h00);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h05);
        push_item(ssq_pkg::CMD_SLEEP, 8'ha1, 32'd2,        6'h10, 6'h00);
        push_item(ssq_pkg::CMD_SLEEP, 8'ha2, 32'd2,        6'h20, 6'h00);
        push_item(ssq_pkg::CMD_SLEEP, 8'ha3, 32'd1,        6'h30, 6'h00);
        push_item(ssq_pkg::CMD_SLEEP, 8'ha4, 32'hffffffff, 6'h3f, 6'h00);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h18);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h18);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h18);
        push_item(ssq_pkg::CMD_SLEEP, 8'h5a, 32'd3,        6'h2a, 6'h15);
        push_item(ssq_pkg::CMD_SLEEP, 8'ha5, 32'd3,        6'h15, 6'h2a);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h15);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h15);
        push_item(ssq_pkg::CMD_TICK,  8'h00, 32'd0,        6'h00, 6'h15);
        wait_drained();

        // receiver holds off while a long sleep burst overflows the queue
        hold_left = HOLD_CYCLES;
        repeat (20) push_item(ssq_pkg::CMD_SLEEP, 8'($urandom), $urandom_range(0, 3),
                              6'($urandom), 6'($urandom));
        repeat (10) push_item(ssq_pkg::CMD_TICK, 8'($urandom), $urandom,
                              6'($urandom), 6'($urandom));
        wait_drained();

        send_idle_pct  = 62;
        recv_stall_pct = 0;
        queue_random(20);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 62;
        queue_random(20);
        wait_drained();

        send_idle_pct  = 6;
        recv_stall_pct = 6;
        queue_random(20);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge clk);
        if (results_due.size() != 0) begin
            $display("%0d expected transfers never arrived", results_due.size());
            mismatches += results_due.size();
        end
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
